### rtl/orbuf_pkg.sv
// ----------------------------------------------------------------------------
// orbuf_pkg
// Shared types and constants for the overwriting ring buffer with absolute
// sequence numbering.
// ----------------------------------------------------------------------------
package orbuf_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int OP_W     = 3;
   localparam int SEQ_W    = 32;
   localparam int WRAP_W   = 28;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH    = 3'd0,
      OP_PULL    = 3'd1,
      OP_READ_AT = 3'd2,
      OP_SKIP    = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic latch;   // capture the request payload
      logic exec;    // apply the operation to pointers and store
      logic load;    // load the response register
   } cmd_type;

endpackage

### rtl/orbuf_if.sv
// ----------------------------------------------------------------------------
// orbuf_req_if / orbuf_rsp_if
// Valid/ready channels for requests and responses of the ring buffer.
// ----------------------------------------------------------------------------
interface orbuf_req_if #(
   parameter int DATA_WIDTH = orbuf_pkg::DATA_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic [orbuf_pkg::OP_W-1:0]     operation;
   logic [DATA_WIDTH-1:0]          push_data;
   logic [orbuf_pkg::SEQ_W-1:0]    seq_index;
   logic [orbuf_pkg::SEQ_W-1:0]    skip_count;

   modport source (output valid, operation, push_data, seq_index, skip_count,
                   input ready);
   modport sink   (input valid, operation, push_data, seq_index, skip_count,
                   output ready);
endinterface

interface orbuf_rsp_if #(
   parameter int DATA_WIDTH = orbuf_pkg::DATA_WIDTH_DEF,
   parameter int CNT_W      = $clog2(orbuf_pkg::DEPTH_DEF)
);
   logic                            valid;
   logic                            ready;
   logic [orbuf_pkg::STATUS_W-1:0]  status;
   logic [DATA_WIDTH-1:0]           read_data;
   logic [CNT_W-1:0]                item_count;
   logic [orbuf_pkg::SEQ_W-1:0]     oldest_seq;
   logic [orbuf_pkg::SEQ_W-1:0]     next_seq;

   modport source (output valid, status, read_data, item_count, oldest_seq, next_seq,
                   input ready);
   modport sink   (input valid, status, read_data, item_count, oldest_seq, next_seq,
                   output ready);
endinterface

### rtl/orbuf_ctrl.sv
// ----------------------------------------------------------------------------
// orbuf_ctrl
// Sequencer: capture request, execute, load response register.
// ----------------------------------------------------------------------------
module orbuf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output orbuf_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign cmd.latch = req_valid && req_ready;
   assign cmd.exec  = (state_ff == S_CALC);
   assign cmd.load  = (state_ff == S_DONE) && rsp_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CALC;
         end
         S_CALC: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait here until the response register can take the result
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### rtl/orbuf_dpath.sv
// ----------------------------------------------------------------------------
// orbuf_dpath
// Pointers, wrap count, data store and response register.
// ----------------------------------------------------------------------------
module orbuf_dpath #(
   parameter int DEPTH      = orbuf_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = orbuf_pkg::DATA_WIDTH_DEF,
   parameter int CNT_W      = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  orbuf_pkg::cmd_type             cmd,
   input  logic [orbuf_pkg::OP_W-1:0]     req_operation,
   input  logic [DATA_WIDTH-1:0]          req_push_data,
   input  logic [orbuf_pkg::SEQ_W-1:0]    req_seq_index,
   input  logic [orbuf_pkg::SEQ_W-1:0]    req_skip_count,
   output logic [orbuf_pkg::STATUS_W-1:0] rsp_status,
   output logic [DATA_WIDTH-1:0]          rsp_read_data,
   output logic [CNT_W-1:0]               rsp_item_count,
   output logic [orbuf_pkg::SEQ_W-1:0]    rsp_oldest_seq,
   output logic [orbuf_pkg::SEQ_W-1:0]    rsp_next_seq
);

   localparam int SEQ_W  = orbuf_pkg::SEQ_W;
   localparam int WRAP_W = orbuf_pkg::WRAP_W;
   localparam int PTR_W  = CNT_W;
   localparam int EXT_W  = PTR_W + 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   // request capture
   orbuf_pkg::op_type     op_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [SEQ_W-1:0]      seq_ff;
   logic [SEQ_W-1:0]      skip_ff;

   // buffer state
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [WRAP_W-1:0] wrap_ff, wrap_in;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] mem_q_ff;
   logic [PTR_W-1:0]      rd_addr;
   logic                  wr_en;

   logic [orbuf_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                           hit_ff, hit_in;

   logic [orbuf_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DATA_WIDTH-1:0]          rsp_data_ff;
   logic [CNT_W-1:0]               rsp_count_ff;
   logic [SEQ_W-1:0]               rsp_oldest_ff;
   logic [SEQ_W-1:0]               rsp_next_ff;

   logic [PTR_W-1:0] cnt_cur;
   logic [SEQ_W-1:0] oldest_cur;
   logic [SEQ_W-1:0] gap;
   logic             in_range;
   logic [EXT_W-1:0] slot_sum;
   logic [PTR_W-1:0] slot;
   logic [PTR_W-1:0] skip_n;
   logic [EXT_W-1:0] skip_sum;
   logic [PTR_W-1:0] skip_pos;
   logic [PTR_W-1:0] push_nxt;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] count(input logic [PTR_W-1:0] wp,
                                              input logic [PTR_W-1:0] rp);
      logic [EXT_W-1:0] d;
      d = {1'b0, wp} - {1'b0, rp};
      if (rp > wp) d = d + EXT_W'(DEPTH);
      return d[PTR_W-1:0];
   endfunction

   function automatic logic [SEQ_W-1:0] seq_of(input logic [WRAP_W-1:0] w,
                                                input logic [PTR_W-1:0]  p);
      logic [SEQ_W-1:0] wx;
      wx = SEQ_W'(w);
      return wx * SEQ_W'(DEPTH) + SEQ_W'(p);
   endfunction

   function automatic logic [SEQ_W-1:0] oldest(input logic [WRAP_W-1:0] w,
                                                input logic [PTR_W-1:0]  wp,
                                                input logic [PTR_W-1:0]  rp);
      // oldest item sits one wrap behind when the read side has not wrapped yet
      return seq_of((rp > wp) ? w - 1'b1 : w, rp);
   endfunction

   assign cnt_cur    = count(wp_ff, rp_ff);
   assign oldest_cur = oldest(wrap_ff, wp_ff, rp_ff);
   assign gap        = seq_ff - oldest_cur;
   assign in_range   = gap < SEQ_W'(cnt_cur);

   // gap and skip are both below DEPTH here, so one subtract wraps the slot
   assign slot_sum = EXT_W'(rp_ff) + EXT_W'(gap[PTR_W-1:0]);
   assign slot     = (slot_sum >= EXT_W'(DEPTH)) ? PTR_W'(slot_sum - EXT_W'(DEPTH))
                                                 : slot_sum[PTR_W-1:0];

   assign skip_n   = (skip_ff < SEQ_W'(cnt_cur)) ? skip_ff[PTR_W-1:0] : cnt_cur;
   assign skip_sum = EXT_W'(rp_ff) + EXT_W'(skip_n);
   assign skip_pos = (skip_sum >= EXT_W'(DEPTH)) ? PTR_W'(skip_sum - EXT_W'(DEPTH))
                                                 : skip_sum[PTR_W-1:0];

   assign push_nxt = bump(wp_ff);

   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      wrap_in   = wrap_ff;
      status_in = orbuf_pkg::STAT_OK;
      hit_in    = 1'b0;
      rd_addr   = rp_ff;
      wr_en     = 1'b0;
      case (op_ff)
         orbuf_pkg::OP_PUSH: begin
            if (push_nxt == '0) wrap_in = wrap_ff + 1'b1;
            // full: drop everything but the word being written
            if (push_nxt == rp_ff) rp_in = wp_ff;
            wr_en = 1'b1;
            wp_in = push_nxt;
         end
         orbuf_pkg::OP_PULL: begin
            if (wp_ff == rp_ff) begin
               status_in = orbuf_pkg::STAT_EMPTY;
            end else begin
               hit_in = 1'b1;
               rp_in  = bump(rp_ff);
            end
         end
         orbuf_pkg::OP_READ_AT: begin
            if (in_range) begin
               hit_in  = 1'b1;
               rd_addr = slot;
            end else begin
               status_in = orbuf_pkg::STAT_RANGE;
            end
         end
         orbuf_pkg::OP_SKIP: begin
            rp_in = skip_pos;
         end
         orbuf_pkg::OP_CLEAR: begin
            wp_in   = '0;
            rp_in   = '0;
            wrap_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= orbuf_pkg::op_type'(req_operation);
         data_ff <= req_push_data;
         seq_ff  <= req_seq_index;
         skip_ff <= req_skip_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         wrap_ff <= '0;
      end else if (cmd.exec) begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         wrap_ff <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_en) mem[wp_ff] <= data_ff;
         mem_q_ff  <= mem[rd_addr];
         status_ff <= status_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= hit_ff ? mem_q_ff : '0;
         rsp_count_ff  <= cnt_cur;
         rsp_oldest_ff <= oldest_cur;
         rsp_next_ff   <= seq_of(wrap_ff, wp_ff);
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_item_count = rsp_count_ff;
   assign rsp_oldest_seq = rsp_oldest_ff;
   assign rsp_next_seq   = rsp_next_ff;

endmodule

### rtl/overwriting_ring_buffer_abs_index_core.sv
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_abs_index_core
// Overwriting ring buffer whose slots are also absolute sequence numbers.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation per transfer: push, pull, read at an absolute
//   sequence number, skip oldest, or clear. Every request gives exactly one
//   transfer on rsp_ch with status, read word, item count, oldest and next
//   sequence numbers as they stand after the operation.
//   A request passes through capture, execute (pointer update, a write to the
//   data store on push and a read from it, read data registered) and response
//   load. The next request is taken in the cycle after the response is loaded;
//   requests do not overlap. The response register holds a finished result
//   while the receiver stalls; a new request may still be captured and
//   executed meanwhile and waits for the register to drain before its own
//   result is loaded.
//   Synchronous reset empties the buffer: positions and wrap count to zero.
//   No clearing pass; store contents stay undefined until written.
//   Item count is CLOG2(DEPTH) bits wide, so at most DEPTH-1 items are held.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_abs_index_core #(
   parameter int DEPTH      = orbuf_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = orbuf_pkg::DATA_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   orbuf_req_if.sink   req_ch,
   orbuf_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(DEPTH);

   orbuf_pkg::cmd_type cmd;

   orbuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   orbuf_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_ch.operation),
      .req_push_data  (req_ch.push_data),
      .req_seq_index  (req_ch.seq_index),
      .req_skip_count (req_ch.skip_count),
      .rsp_status     (rsp_ch.status),
      .rsp_read_data  (rsp_ch.read_data),
      .rsp_item_count (rsp_ch.item_count),
      .rsp_oldest_seq (rsp_ch.oldest_seq),
      .rsp_next_seq   (rsp_ch.next_seq)
   );

endmodule
